>>> rtl/fbhd_pkg.sv
// shared types, constants and register indexes of the field boundary halt debouncer
// no dependencies
`timescale 1ns / 1ps

package fbhd_pkg;

	localparam int POS_WIDTH = 16;
	localparam int HALF_WIDTH = 15;
	localparam int DBN_WIDTH = 4;
	localparam int LOST_WIDTH = 8;
	localparam int CFG_ADDR_WIDTH = 3;
	localparam int CFG_DATA_WIDTH = 15;

	// compare width: holds |pos| and the shrunk limit with a sign bit
	localparam int CMP_WIDTH = ((POS_WIDTH > HALF_WIDTH) ? POS_WIDTH : HALF_WIDTH) + 2;

	localparam logic [CFG_ADDR_WIDTH-1:0] REG_FIELD_HALF_X = 3'd0;
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_FIELD_HALF_Y = 3'd1;
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_REL_MARGIN = 3'd2;
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_OOB_DEBOUNCE = 3'd3;
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_BALL_LOST_TICKS = 3'd4;

	localparam logic [HALF_WIDTH-1:0] RST_FIELD_HALF_X = 15'd4500;
	localparam logic [HALF_WIDTH-1:0] RST_FIELD_HALF_Y = 15'd3000;
	localparam logic [HALF_WIDTH-1:0] RST_REL_MARGIN = 15'd200;
	localparam logic [DBN_WIDTH-1:0] RST_OOB_DEBOUNCE = 4'd10;
	localparam logic [LOST_WIDTH-1:0] RST_BALL_LOST_TICKS = 8'd150;

	localparam logic [LOST_WIDTH-1:0] LOST_MAX = {LOST_WIDTH{1'b1}};

	typedef struct packed {
		logic outside;
		logic in_shrunk;
	} fbhd_bounds_t;

	typedef struct packed {
		logic [DBN_WIDTH-1:0] count;
		logic halted;
		logic set_pause;
		logic clr_pause;
	} fbhd_dbn_t;

endpackage

>>> rtl/field_boundary_halt_debouncer.sv
// top level of the field boundary halt debouncer: handshakes, config and tick state
// depends on fbhd_pkg, fbhd_bounds, fbhd_debounce
`timescale 1ns / 1ps

// One request is one control tick: robot position, start/stop buttons and an
// optional new ball position. Each request gives exactly one result holding
// start, pause and agent-stop flags, ball-seen and the two halt states as they
// stand after that tick. A request is captured in an input register and the
// whole tick update (lost timer, button logic, boundary compares, both debounce
// counters) runs combinationally between that register and the result register.
// While the result channel is not stalled, one request per cycle is sustained.
// Stop wins over start. A halt is released only strictly inside the field shrunk
// by the release margin; the ball counter only falls while the ball is not seen.
// Configuration registers are written through cfg_we/cfg_addr/cfg_data. The user
// must write them only while idle; the block itself does not enforce this.
module field_boundary_halt_debouncer import fbhd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	// configuration
	input  logic cfg_we,
	input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
	// input channel
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [POS_WIDTH-1:0] robot_x,
	input  logic signed [POS_WIDTH-1:0] robot_y,
	input  logic start_button,
	input  logic stop_button,
	input  logic ball_update,
	input  logic signed [POS_WIDTH-1:0] ball_x,
	input  logic signed [POS_WIDTH-1:0] ball_y,
	// result channel
	output logic out_valid,
	input  logic out_ready,
	output logic start_flag,
	output logic pause_flag,
	output logic agent_halt,
	output logic ball_seen,
	output logic robot_halt,
	output logic ball_halt
);

	// configuration registers
	logic [HALF_WIDTH-1:0] field_half_x_q, field_half_y_q, rel_margin_q;
	logic [DBN_WIDTH-1:0] oob_debounce_q;
	logic [LOST_WIDTH-1:0] ball_lost_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_half_x_q <= RST_FIELD_HALF_X;
			field_half_y_q <= RST_FIELD_HALF_Y;
			rel_margin_q <= RST_REL_MARGIN;
			oob_debounce_q <= RST_OOB_DEBOUNCE;
			ball_lost_ticks_q <= RST_BALL_LOST_TICKS;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FIELD_HALF_X: field_half_x_q <= cfg_data[HALF_WIDTH-1:0];
				REG_FIELD_HALF_Y: field_half_y_q <= cfg_data[HALF_WIDTH-1:0];
				REG_REL_MARGIN: rel_margin_q <= cfg_data[HALF_WIDTH-1:0];
				REG_OOB_DEBOUNCE: oob_debounce_q <= cfg_data[DBN_WIDTH-1:0];
				REG_BALL_LOST_TICKS: ball_lost_ticks_q <= cfg_data[LOST_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// input register stage
	logic valid_s1;
	logic signed [POS_WIDTH-1:0] robot_x_s1, robot_y_s1, ball_x_s1, ball_y_s1;
	logic start_s1, stop_s1, update_s1;
	logic advance;

	// the tick moves into the result register whenever that register is free or drains
	assign advance = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			robot_x_s1 <= robot_x;
			robot_y_s1 <= robot_y;
			start_s1 <= start_button;
			stop_s1 <= stop_button;
			update_s1 <= ball_update;
			ball_x_s1 <= ball_x;
			ball_y_s1 <= ball_y;
		end
	end

	// tick state
	logic start_q, pause_q, agent_stop_q, ball_valid_q;
	logic [LOST_WIDTH-1:0] lost_count_q;
	logic signed [POS_WIDTH-1:0] last_ball_x_q, last_ball_y_q;
	logic [DBN_WIDTH-1:0] robot_count_q, ball_count_q;
	logic robot_halted_q, ball_halted_q;

	// next-state logic for one tick
	logic start_n, pause_btn, agent_n, ball_valid_n, pause_mid, pause_n;
	logic [LOST_WIDTH-1:0] lost_n;
	logic signed [POS_WIDTH-1:0] bx_n, by_n;
	fbhd_bounds_t robot_bnd, ball_bnd;
	fbhd_dbn_t robot_dbn, ball_dbn;

	always_comb begin
		// lost timer saturates, a fresh ball position clears it
		lost_n = (lost_count_q == LOST_MAX) ? LOST_MAX : lost_count_q + 1'b1;
		start_n = start_q;
		pause_btn = pause_q;
		agent_n = agent_stop_q;
		if (start_s1) begin
			start_n = 1'b1;
			pause_btn = 1'b0;
			agent_n = 1'b0;
		end
		// stop applied after start so it wins
		if (stop_s1) begin
			start_n = 1'b0;
			pause_btn = 1'b1;
			agent_n = 1'b1;
		end
		ball_valid_n = ball_valid_q;
		bx_n = last_ball_x_q;
		by_n = last_ball_y_q;
		if (update_s1) begin
			bx_n = ball_x_s1;
			by_n = ball_y_s1;
			lost_n = '0;
			ball_valid_n = 1'b1;
		end
		if (lost_n >= ball_lost_ticks_q) begin
			ball_valid_n = 1'b0;
		end
	end

	fbhd_bounds u_robot_bounds (
		.pos_x(robot_x_s1),
		.pos_y(robot_y_s1),
		.half_x(field_half_x_q),
		.half_y(field_half_y_q),
		.margin(rel_margin_q),
		.bounds(robot_bnd)
	);

	fbhd_bounds u_ball_bounds (
		.pos_x(bx_n),
		.pos_y(by_n),
		.half_x(field_half_x_q),
		.half_y(field_half_y_q),
		.margin(rel_margin_q),
		.bounds(ball_bnd)
	);

	fbhd_debounce u_robot_dbn (
		.count(robot_count_q),
		.halted(robot_halted_q),
		.is_out(robot_bnd.outside),
		.may_release(robot_bnd.in_shrunk),
		.limit(oob_debounce_q),
		.nxt(robot_dbn)
	);

	// an unseen ball only lets the counter fall and holds its halt
	fbhd_debounce u_ball_dbn (
		.count(ball_count_q),
		.halted(ball_halted_q),
		.is_out(ball_valid_n && ball_bnd.outside),
		.may_release(ball_valid_n && ball_bnd.in_shrunk),
		.limit(oob_debounce_q),
		.nxt(ball_dbn)
	);

	// robot debounce acts on pause first, then the ball debounce
	always_comb begin
		pause_mid = robot_dbn.set_pause ? 1'b1 : (robot_dbn.clr_pause ? 1'b0 : pause_btn);
		pause_n = ball_dbn.set_pause ? 1'b1 : (ball_dbn.clr_pause ? 1'b0 : pause_mid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
			pause_q <= 1'b0;
			agent_stop_q <= 1'b0;
			ball_valid_q <= 1'b0;
			lost_count_q <= '0;
			last_ball_x_q <= '0;
			last_ball_y_q <= '0;
			robot_count_q <= '0;
			robot_halted_q <= 1'b0;
			ball_count_q <= '0;
			ball_halted_q <= 1'b0;
		end else if (advance) begin
			start_q <= start_n;
			pause_q <= pause_n;
			agent_stop_q <= agent_n;
			ball_valid_q <= ball_valid_n;
			lost_count_q <= lost_n;
			last_ball_x_q <= bx_n;
			last_ball_y_q <= by_n;
			robot_count_q <= robot_dbn.count;
			robot_halted_q <= robot_dbn.halted;
			ball_count_q <= ball_dbn.count;
			ball_halted_q <= ball_dbn.halted;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			start_flag <= start_n;
			pause_flag <= pause_n;
			agent_halt <= agent_n;
			ball_seen <= ball_valid_n;
			robot_halt <= robot_dbn.halted;
			ball_halt <= ball_dbn.halted;
		end
	end

endmodule

>>> rtl/fbhd_bounds.sv
// field boundary compares for one position: outside the field, inside the shrunk field
// depends on fbhd_pkg
`timescale 1ns / 1ps

module fbhd_bounds import fbhd_pkg::*; (
	input  logic signed [POS_WIDTH-1:0] pos_x,
	input  logic signed [POS_WIDTH-1:0] pos_y,
	input  logic [HALF_WIDTH-1:0] half_x,
	input  logic [HALF_WIDTH-1:0] half_y,
	input  logic [HALF_WIDTH-1:0] margin,
	output fbhd_bounds_t bounds
);

	logic signed [CMP_WIDTH-1:0] ext_x, ext_y, abs_x, abs_y;
	logic signed [CMP_WIDTH-1:0] lim_x, lim_y, safe_x, safe_y, mrg;

	always_comb begin
		ext_x = CMP_WIDTH'(pos_x);
		ext_y = CMP_WIDTH'(pos_y);
		abs_x = ext_x[CMP_WIDTH-1] ? -ext_x : ext_x;
		abs_y = ext_y[CMP_WIDTH-1] ? -ext_y : ext_y;
		lim_x = $signed(CMP_WIDTH'(half_x));
		lim_y = $signed(CMP_WIDTH'(half_y));
		mrg = $signed(CMP_WIDTH'(margin));
		// negative when the margin exceeds the half field: release never happens
		safe_x = lim_x - mrg;
		safe_y = lim_y - mrg;
		bounds.outside = (abs_x > lim_x) || (abs_y > lim_y);
		bounds.in_shrunk = (abs_x < safe_x) && (abs_y < safe_y);
	end

endmodule

>>> rtl/fbhd_debounce.sv
// saturating up/down out-of-bounds counter with hysteresis halt release
// depends on fbhd_pkg
`timescale 1ns / 1ps

module fbhd_debounce import fbhd_pkg::*; (
	input  logic [DBN_WIDTH-1:0] count,
	input  logic halted,
	input  logic is_out,
	input  logic may_release,
	input  logic [DBN_WIDTH-1:0] limit,
	output fbhd_dbn_t nxt
);

	logic [DBN_WIDTH:0] inc;
	logic [DBN_WIDTH-1:0] cnt;

	always_comb begin
		inc = {1'b0, count} + 1'b1;
		if (is_out) begin
			cnt = (inc < {1'b0, limit}) ? inc[DBN_WIDTH-1:0] : limit;
		end else begin
			cnt = (count != '0) ? count - 1'b1 : '0;
		end
		nxt.count = cnt;
		nxt.set_pause = 1'b0;
		nxt.clr_pause = 1'b0;
		nxt.halted = halted;
		if (cnt >= limit) begin
			nxt.halted = 1'b1;
			nxt.set_pause = 1'b1;
		end else if (halted && may_release) begin
			nxt.halted = 1'b0;
			nxt.clr_pause = 1'b1;
		end
	end

endmodule
